// ----- src/olpm_pkg.sv -----
// olpm_pkg: shared constants, command/status types and the rounding helper
// for the logistic probability mixer. No dependencies.
package olpm_pkg;

  localparam int FEATURE_COUNT = 5;
  localparam int PROB_BITS_DEF = 16;
  localparam int PROB_W        = 16;
  localparam int IDX_W         = 3;
  localparam int BIT_W         = 4;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;
  localparam int LS_W          = 22;
  localparam int DF_W          = 16;
  localparam int STR_W         = 18;
  localparam int Z_W           = 24;
  localparam int W_W           = 32;
  localparam int F_W           = 16;
  localparam int ACC_W         = 51;
  localparam int GRAD_W        = 44;
  localparam int RND_W         = 72;

  localparam logic [LS_W-1:0]       LS_RESET     = 22'd128849;
  localparam logic [DF_W-1:0]       DF_RESET     = 16'd429;
  localparam logic [CFG_IDX_W-1:0]  REG_LEARNING_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_DECAY_FACTOR  = 8'd1;
  localparam logic [32:0]           LN2_Q32      = 33'd2977044472;
  localparam logic signed [F_W-1:0] FEAT_LIMIT   = 16'sd24576;
  localparam logic signed [F_W-1:0] FEAT_BIAS    = 16'sd4096;
  localparam logic signed [W_W-1:0] WEIGHT_LIMIT = 32'sd536870912;
  localparam logic [IDX_W-1:0]      LAST_FEAT    = 3'(FEATURE_COUNT - 1);
  localparam logic [IDX_W-1:0]      LAST_PROB    = 3'(FEATURE_COUNT - 2);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_STR_PROB,
    OP_STR_SAVE,
    OP_FEAT,
    OP_DOT_MUL,
    OP_DOT_ACC,
    OP_Z,
    OP_SQ_START,
    OP_SQ_CMP,
    OP_OUT,
    OP_U_ERRF,
    OP_U_DECAY,
    OP_U_GRAD,
    OP_U_LO,
    OP_U_HI,
    OP_U_STEP,
    OP_U_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
    logic [BIT_W-1:0] bit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic str_done;
  } dp_stat_t;

  // arithmetic shift right with round to nearest, ties away from zero
  function automatic logic signed [RND_W-1:0] round_sh(input logic signed [RND_W-1:0] x,
                                                       input int unsigned s);
    logic [RND_W-1:0] half;
    logic [RND_W-1:0] mag;
    half = RND_W'(1) << (s - 1);
    if (!x[RND_W-1]) begin
      mag = (RND_W'(x) + half) >> s;
      return signed'(mag);
    end else begin
      mag = (RND_W'(-x) + half) >> s;
      return -signed'(mag);
    end
  endfunction

endpackage

// ----- src/olpm_ifs.sv -----
// olpm_ifs: valid/ready channel interfaces for predict/update items,
// mixed results and register writes. Depends on olpm_pkg.
interface olpm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [olpm_pkg::PROB_W-1:0]  prob_bit_model;
  logic [olpm_pkg::PROB_W-1:0]  prob_byte_model;
  logic [olpm_pkg::PROB_W-1:0]  prob_word_model;
  logic [olpm_pkg::PROB_W-1:0]  prob_semantic_model;
  logic                         coded_bit;
  modport source (output valid, func, prob_bit_model, prob_byte_model, prob_word_model,
                  prob_semantic_model, coded_bit, input ready);
  modport sink (input valid, func, prob_bit_model, prob_byte_model, prob_word_model,
                prob_semantic_model, coded_bit, output ready);
endinterface

interface olpm_out_if;
  logic                         valid;
  logic                         ready;
  logic [olpm_pkg::PROB_W-1:0]  mixed_probability;
  modport source (output valid, mixed_probability, input ready);
  modport sink (input valid, mixed_probability, output ready);
endinterface

interface olpm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [olpm_pkg::CFG_IDX_W-1:0]  index;
  logic [olpm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/olpm_stretch.sv -----
// olpm_stretch: iterative stretch unit, ln(p/(1-p)) in Q.12 from two log2
// evaluations by repeated squaring. Depends on olpm_pkg.
module olpm_stretch #(
  parameter int PROB_BITS = olpm_pkg::PROB_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [PROB_BITS-1:0]              p,
  output logic                              done,
  output logic signed [olpm_pkg::STR_W-1:0] result
);

  localparam int E_W = $clog2(PROB_BITS);
  localparam int LW  = E_W + 16;
  localparam int PW  = LW + 35;

  typedef enum logic [2:0] {S_IDLE, S_NORM, S_SQ, S_MUL, S_RND} st_t;

  st_t                              st_r;
  logic                             phase_r;
  logic [3:0]                       cnt_r;
  logic [PROB_BITS-1:0]             p_r;
  logic [PROB_BITS-1:0]             x_r;
  logic [31:0]                      m_r;
  logic [15:0]                      frac_r;
  logic [E_W-1:0]                   e_r;
  logic [LW-1:0]                    la_r;
  logic signed [LW:0]               d_r;
  logic signed [PW-1:0]             prod_r;
  logic signed [olpm_pkg::STR_W-1:0] result_r;
  logic                             done_r;

  logic [E_W-1:0] e_c;
  logic [63:0]    sq_c;
  logic [32:0]    t_c;
  logic [15:0]    frac_nxt;
  logic [LW-1:0]  lg_c;

  // leading one of the argument
  always_comb begin
    e_c = '0;
    for (int i = 0; i < PROB_BITS; i++) begin
      if (x_r[i]) e_c = E_W'(i);
    end
  end

  assign sq_c     = m_r * m_r;
  assign t_c      = sq_c[63:31];
  assign frac_nxt = {frac_r[14:0], t_c[32]};
  assign lg_c     = {e_r, frac_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            p_r     <= p;
            x_r     <= p;
            phase_r <= 1'b0;
            st_r    <= S_NORM;
          end
        end
        S_NORM: begin
          m_r    <= 32'(x_r) << (5'd31 - 5'(e_c));
          e_r    <= e_c;
          frac_r <= '0;
          cnt_r  <= '0;
          st_r   <= S_SQ;
        end
        S_SQ: begin
          frac_r <= frac_nxt;
          m_r    <= t_c[32] ? t_c[32:1] : t_c[31:0];
          cnt_r  <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            if (!phase_r) begin
              la_r    <= lg_c;
              x_r     <= ~p_r + 1'b1;
              phase_r <= 1'b1;
              st_r    <= S_NORM;
            end else begin
              d_r  <= signed'({1'b0, la_r}) - signed'({1'b0, lg_c});
              st_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r <= d_r * signed'({1'b0, olpm_pkg::LN2_Q32});
          st_r   <= S_RND;
        end
        S_RND: begin
          result_r <= olpm_pkg::STR_W'(olpm_pkg::round_sh(olpm_pkg::RND_W'(prod_r), 36));
          done_r   <= 1'b1;
          st_r     <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("stretch done held longer than one cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> st_r == S_IDLE)
    else $error("stretch started while busy");
  a_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SQ && cnt_r == 4'd15 && phase_r) |=> st_r == S_MUL)
    else $error("stretch skipped the scaling multiply");

endmodule

// ----- src/olpm_datapath.sv -----
// olpm_datapath: weights, features, dot product, squash search and weight
// update registers, driven by controller commands. Depends on olpm_pkg, olpm_stretch.
module olpm_datapath #(
  parameter int PROB_BITS = olpm_pkg::PROB_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  olpm_pkg::dp_cmd_t                  cmd,
  output olpm_pkg::dp_stat_t                 stat,
  input  logic [olpm_pkg::PROB_W-1:0]        prob_bit_model,
  input  logic [olpm_pkg::PROB_W-1:0]        prob_byte_model,
  input  logic [olpm_pkg::PROB_W-1:0]        prob_word_model,
  input  logic [olpm_pkg::PROB_W-1:0]        prob_semantic_model,
  input  logic                               coded_bit,
  input  logic                               cfg_we,
  input  logic [olpm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [olpm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [olpm_pkg::PROB_W-1:0]        mixed_probability
);

  localparam int SD_W = olpm_pkg::STR_W + 1;
  localparam int ERR_W = PROB_BITS + 2;
  localparam int EF_W = ERR_W + olpm_pkg::F_W;
  localparam int DW_W = olpm_pkg::DF_W + 1 + olpm_pkg::W_W;
  localparam int PR_W = olpm_pkg::W_W + olpm_pkg::F_W;
  localparam int STEP_W = 40;
  localparam int RND_W = olpm_pkg::RND_W;

  logic [olpm_pkg::LS_W-1:0]          ls_r;
  logic [olpm_pkg::DF_W-1:0]          df_r;
  logic [PROB_BITS-1:0]               p_r [4];
  logic                               bit_r;
  logic signed [olpm_pkg::STR_W-1:0]  s_r [4];
  logic signed [olpm_pkg::F_W-1:0]    f_r [olpm_pkg::FEATURE_COUNT];
  logic signed [olpm_pkg::W_W-1:0]    w_r [olpm_pkg::FEATURE_COUNT];
  logic signed [PR_W-1:0]             prod_r;
  logic signed [olpm_pkg::ACC_W-1:0]  acc_r;
  logic signed [olpm_pkg::Z_W-1:0]    z_r;
  logic [PROB_BITS-1:0]               res_r;
  logic [PROB_BITS-1:0]               last_r;
  logic signed [EF_W-1:0]             ef_r;
  logic signed [DW_W-1:0]             dw_r;
  logic signed [olpm_pkg::GRAD_W-1:0] grad_r;
  logic [olpm_pkg::GRAD_W-1:0]        plo_r;
  logic signed [olpm_pkg::GRAD_W:0]   phi_r;
  logic signed [STEP_W-1:0]           step_r;

  logic                              str_start;
  logic [PROB_BITS-1:0]              str_p;
  logic                              str_done;
  logic signed [olpm_pkg::STR_W-1:0] str_res;
  logic [PROB_BITS-1:0]              cand_c;
  logic signed [ERR_W-1:0]           err_c;
  logic signed [RND_W-1:0]           full_c;
  logic signed [RND_W-1:0]           wn_c;

  function automatic logic [PROB_BITS-1:0] clamp_p(input logic [olpm_pkg::PROB_W-1:0] v);
    logic [PROB_BITS-1:0] t;
    t = v[PROB_BITS-1:0];
    return (t == '0) ? PROB_BITS'(1) : t;
  endfunction

  function automatic logic signed [olpm_pkg::F_W-1:0] clamp_f(input logic signed [SD_W-1:0] v);
    if (v > olpm_pkg::FEAT_LIMIT) return olpm_pkg::FEAT_LIMIT;
    if (v < -olpm_pkg::FEAT_LIMIT) return -olpm_pkg::FEAT_LIMIT;
    return olpm_pkg::F_W'(v);
  endfunction

  assign cand_c    = res_r | (PROB_BITS'(1) << cmd.bit_sel);
  assign str_start = (cmd.op == olpm_pkg::OP_STR_PROB) || (cmd.op == olpm_pkg::OP_SQ_START);
  assign str_p     = (cmd.op == olpm_pkg::OP_SQ_START) ? cand_c : p_r[cmd.idx[1:0]];

  olpm_stretch #(.PROB_BITS(PROB_BITS)) u_stretch (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (str_start),
    .p      (str_p),
    .done   (str_done),
    .result (str_res)
  );

  assign err_c = signed'({2'b00, last_r})
               - (bit_r ? signed'({2'b01, {PROB_BITS{1'b0}}}) : ERR_W'(0));
  assign full_c = (RND_W'(phi_r) <<< olpm_pkg::LS_W) + RND_W'(signed'({1'b0, plo_r}));
  assign wn_c   = RND_W'(w_r[cmd.idx]) - RND_W'(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ls_r   <= olpm_pkg::LS_RESET;
      df_r   <= olpm_pkg::DF_RESET;
      last_r <= PROB_BITS'(1) << (PROB_BITS - 1);
      for (int i = 0; i < olpm_pkg::FEATURE_COUNT; i++) begin
        w_r[i] <= '0;
        f_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_idx == olpm_pkg::REG_LEARNING_STEP) begin
          ls_r <= cfg_data[olpm_pkg::LS_W-1:0];
        end else if (cfg_idx == olpm_pkg::REG_DECAY_FACTOR) begin
          df_r <= cfg_data[olpm_pkg::DF_W-1:0];
        end
      end
      unique case (cmd.op)
        olpm_pkg::OP_LOAD: begin
          p_r[0] <= clamp_p(prob_bit_model);
          p_r[1] <= clamp_p(prob_byte_model);
          p_r[2] <= clamp_p(prob_word_model);
          p_r[3] <= clamp_p(prob_semantic_model);
          bit_r  <= coded_bit;
        end
        olpm_pkg::OP_STR_SAVE: s_r[cmd.idx[1:0]] <= str_res;
        olpm_pkg::OP_FEAT: begin
          f_r[0] <= olpm_pkg::FEAT_BIAS;
          f_r[1] <= clamp_f(SD_W'(s_r[0]));
          for (int i = 2; i < olpm_pkg::FEATURE_COUNT; i++) begin
            f_r[i] <= clamp_f(SD_W'(s_r[i-1]) - SD_W'(s_r[0]));
          end
          acc_r <= '0;
        end
        olpm_pkg::OP_DOT_MUL: prod_r <= w_r[cmd.idx] * f_r[cmd.idx];
        olpm_pkg::OP_DOT_ACC: acc_r <= acc_r + olpm_pkg::ACC_W'(prod_r);
        olpm_pkg::OP_Z: begin
          z_r   <= olpm_pkg::Z_W'(s_r[0])
                 + olpm_pkg::Z_W'(olpm_pkg::round_sh(RND_W'(acc_r), 28));
          res_r <= '0;
        end
        olpm_pkg::OP_SQ_CMP: begin
          if (olpm_pkg::Z_W'(str_res) <= z_r) res_r <= cand_c;
        end
        olpm_pkg::OP_OUT:    last_r <= res_r;
        olpm_pkg::OP_U_ERRF: ef_r <= err_c * f_r[cmd.idx];
        olpm_pkg::OP_U_DECAY: dw_r <= signed'({1'b0, df_r}) * w_r[cmd.idx];
        olpm_pkg::OP_U_GRAD: begin
          grad_r <= (olpm_pkg::GRAD_W'(ef_r) <<< (24 - PROB_BITS))
                  + olpm_pkg::GRAD_W'(olpm_pkg::round_sh(RND_W'(dw_r), 24));
        end
        olpm_pkg::OP_U_LO: plo_r <= ls_r * grad_r[olpm_pkg::LS_W-1:0];
        olpm_pkg::OP_U_HI: begin
          phi_r <= signed'({1'b0, ls_r}) * signed'(grad_r[olpm_pkg::GRAD_W-1:olpm_pkg::LS_W]);
        end
        olpm_pkg::OP_U_STEP: step_r <= STEP_W'(olpm_pkg::round_sh(full_c, 40));
        olpm_pkg::OP_U_WR: begin
          if (wn_c > RND_W'(olpm_pkg::WEIGHT_LIMIT)) begin
            w_r[cmd.idx] <= olpm_pkg::WEIGHT_LIMIT;
          end else if (wn_c < -RND_W'(olpm_pkg::WEIGHT_LIMIT)) begin
            w_r[cmd.idx] <= -olpm_pkg::WEIGHT_LIMIT;
          end else begin
            w_r[cmd.idx] <= olpm_pkg::W_W'(wn_c);
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.str_done     = str_done;
  assign mixed_probability = olpm_pkg::PROB_W'(last_r);

endmodule

// ----- src/olpm_ctrl.sv -----
// olpm_ctrl: sequencer for predict and update items, output valid register
// and pending flag. Depends on olpm_pkg.
module olpm_ctrl #(
  parameter int PROB_BITS = olpm_pkg::PROB_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  olpm_pkg::dp_stat_t  stat,
  output olpm_pkg::dp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_STR_GO, S_STR_WAIT, S_FEAT, S_DMUL, S_DACC, S_ZC, S_SQ_GO, S_SQ_WAIT,
    S_OUT, S_U_EF, S_U_DC, S_U_GR, S_U_LO, S_U_HI, S_U_ST, S_U_WR
  } state_t;

  state_t                         state_r;
  logic [olpm_pkg::IDX_W-1:0]     idx_r;
  logic [olpm_pkg::BIT_W-1:0]     bit_r;
  logic                           pending_r;
  logic                           out_valid_r;
  logic                           accept;
  logic                           out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '{op: olpm_pkg::OP_NONE, idx: idx_r, bit_sel: bit_r};
    unique case (state_r)
      S_IDLE:     if (accept) cmd.op = olpm_pkg::OP_LOAD;
      S_STR_GO:   cmd.op = olpm_pkg::OP_STR_PROB;
      S_STR_WAIT: if (stat.str_done) cmd.op = olpm_pkg::OP_STR_SAVE;
      S_FEAT:     cmd.op = olpm_pkg::OP_FEAT;
      S_DMUL:     cmd.op = olpm_pkg::OP_DOT_MUL;
      S_DACC:     cmd.op = olpm_pkg::OP_DOT_ACC;
      S_ZC:       cmd.op = olpm_pkg::OP_Z;
      S_SQ_GO:    cmd.op = olpm_pkg::OP_SQ_START;
      S_SQ_WAIT:  if (stat.str_done) cmd.op = olpm_pkg::OP_SQ_CMP;
      S_OUT:      if (out_free) cmd.op = olpm_pkg::OP_OUT;
      S_U_EF:     cmd.op = olpm_pkg::OP_U_ERRF;
      S_U_DC:     cmd.op = olpm_pkg::OP_U_DECAY;
      S_U_GR:     cmd.op = olpm_pkg::OP_U_GRAD;
      S_U_LO:     cmd.op = olpm_pkg::OP_U_LO;
      S_U_HI:     cmd.op = olpm_pkg::OP_U_HI;
      S_U_ST:     cmd.op = olpm_pkg::OP_U_STEP;
      S_U_WR:     cmd.op = olpm_pkg::OP_U_WR;
      default:    cmd.op = olpm_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      bit_r       <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r <= '0;
            if (!in_func) begin
              state_r <= S_STR_GO;
            end else begin
              pending_r <= 1'b0;
              if (pending_r) state_r <= S_U_EF;
            end
          end
        end
        S_STR_GO: state_r <= S_STR_WAIT;
        S_STR_WAIT: begin
          if (stat.str_done) begin
            if (idx_r == olpm_pkg::LAST_PROB) begin
              idx_r   <= '0;
              state_r <= S_FEAT;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_STR_GO;
            end
          end
        end
        S_FEAT: state_r <= S_DMUL;
        S_DMUL: state_r <= S_DACC;
        S_DACC: begin
          if (idx_r == olpm_pkg::LAST_FEAT) begin
            bit_r   <= olpm_pkg::BIT_W'(PROB_BITS - 1);
            state_r <= S_ZC;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_DMUL;
          end
        end
        S_ZC:    state_r <= S_SQ_GO;
        S_SQ_GO: state_r <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (stat.str_done) begin
            if (bit_r == '0) begin
              state_r <= S_OUT;
            end else begin
              bit_r   <= bit_r - 1'b1;
              state_r <= S_SQ_GO;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            pending_r   <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_U_EF: state_r <= S_U_DC;
        S_U_DC: state_r <= S_U_GR;
        S_U_GR: state_r <= S_U_LO;
        S_U_LO: state_r <= S_U_HI;
        S_U_HI: state_r <= S_U_ST;
        S_U_ST: state_r <= S_U_WR;
        S_U_WR: begin
          if (idx_r == olpm_pkg::LAST_FEAT) begin
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_U_EF;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_idle_update: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func && !pending_r) |=> (state_r == S_IDLE && !pending_r))
    else $error("update with nothing pending left idle");
  a_out_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_valid_r && pending_r))
    else $error("result issued without pending flag");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DMUL || state_r == S_U_EF || state_r == S_U_WR) |->
    idx_r <= olpm_pkg::LAST_FEAT)
    else $error("feature index out of range");

endmodule

// ----- src/online_logistic_probability_mixer.sv -----
// online_logistic_probability_mixer: top level, controller plus datapath.
// Predict item: stretch each model probability, build features, dot product, then a bitwise squash
// search with one stretch per result bit (iterative stretch unit: 16 squarings per log2, two log2 per stretch).
// Update item: per-weight gradient, step and clamped write if a prediction is pending, else no-op.
// One item at a time; a finished word waits in the output register while the next is taken.
// Synchronous active-low reset: weights and features zero, last output one half, no update pending.
module online_logistic_probability_mixer #(
  parameter int PROB_BITS = olpm_pkg::PROB_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  olpm_in_if.sink      in_ch,
  olpm_out_if.source   out_ch,
  olpm_cfg_if.sink     cfg_ch
);

  olpm_pkg::dp_cmd_t  cmd;
  olpm_pkg::dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  olpm_ctrl #(.PROB_BITS(PROB_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  olpm_datapath #(.PROB_BITS(PROB_BITS)) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .prob_bit_model      (in_ch.prob_bit_model),
    .prob_byte_model     (in_ch.prob_byte_model),
    .prob_word_model     (in_ch.prob_word_model),
    .prob_semantic_model (in_ch.prob_semantic_model),
    .coded_bit           (in_ch.coded_bit),
    .cfg_we              (cfg_ch.valid),
    .cfg_idx             (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .mixed_probability   (out_ch.mixed_probability)
  );

endmodule

// ----- tb/olpm_tb_pkg.sv -----
// olpm_tb_pkg: item function codes shared by the mixer checker and testbench top.
// No dependencies.
package olpm_tb_pkg;

  localparam logic FN_PREDICT = 1'b0;
  localparam logic FN_UPDATE  = 1'b1;

endpackage

// ----- tb/olpm_mix_checker.sv -----
// olpm_mix_checker: watches the item, result and register channels of the mixer,
// predicts each mixed probability and compares. Depends on olpm_pkg, olpm_tb_pkg, olpm_ifs.
module olpm_mix_checker (
  input  logic clk,
  input  logic rst_n,
  olpm_in_if   in_mon,
  olpm_out_if  out_mon,
  olpm_cfg_if  cfg_mon,
  output int   err_count,
  output int   open_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import olpm_pkg::*;
  import olpm_tb_pkg::*;

  localparam longint PMAX   = 65535;
  localparam longint LN2    = 64'd2977044472;
  localparam longint FLIM   = 24576;
  localparam longint WLIM   = 64'sd536870912;

  logic [LS_W-1:0]  rate_q;
  logic [DF_W-1:0]  decay_q;
  longint           wt [FEATURE_COUNT];
  longint           feat [FEATURE_COUNT];
  longint           prev_mix;
  bit               armed;
  logic [PROB_W-1:0] mix_q[$];

  function automatic longint rnd_shr(longint x, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (x >= 0) return (x + half) >>> s;
    return -((-x + half) >>> s);
  endfunction

  function automatic longint log2_fix(longint x);
    int e;
    longint unsigned m;
    longint fr;
    e = 0;
    fr = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = longint'(x) << (31 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= (64'd1 << 32)) begin
        fr = fr | 1;
        m = m >> 1;
      end
    end
    return (longint'(e) << 16) + fr;
  endfunction

  function automatic longint log_odds(longint p);
    longint d;
    if (p < 1) p = 1;
    if (p > PMAX) p = PMAX;
    d = log2_fix(p) - log2_fix(65536 - p);
    return rnd_shr(d * LN2, 36);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint inv_log_odds(longint z);
    longint r, c;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      c = r | (longint'(1) << b);
      if (c <= PMAX && log_odds(c) <= z) r = c;
    end
    return r;
  endfunction

  task automatic mix_predict(input logic [PROB_W-1:0] p [4]);
    longint base, acc;
    base = log_odds(p[0]);
    feat[0] = 4096;
    feat[1] = clip(base, -FLIM, FLIM);
    for (int i = 2; i < FEATURE_COUNT; i++)
      feat[i] = clip(log_odds(p[i-1]) - base, -FLIM, FLIM);
    acc = 0;
    for (int i = 0; i < FEATURE_COUNT; i++) acc += wt[i] * feat[i];
    prev_mix = inv_log_odds(base + rnd_shr(acc, 28));
    armed = 1;
    mix_q.push_back(PROB_W'(prev_mix));
  endtask

  task automatic mix_learn(input logic cbit);
    longint e, g, st;
    if (armed) begin
      e = prev_mix - (cbit ? 65536 : 0);
      for (int i = 0; i < FEATURE_COUNT; i++) begin
        g = e * feat[i] * 256 + rnd_shr(longint'(decay_q) * wt[i], 24);
        st = rnd_shr(longint'(rate_q) * g, 40);
        wt[i] = clip(wt[i] - st, -WLIM, WLIM);
      end
    end
    armed = 0;
  endtask

  always @(posedge clk) begin
    logic [PROB_W-1:0] pr [4];
    logic [PROB_W-1:0] want;
    if (!rst_n) begin
      rate_q <= LS_RESET;
      decay_q <= DF_RESET;
      for (int i = 0; i < FEATURE_COUNT; i++) begin
        wt[i] = 0;
        feat[i] = 0;
      end
      prev_mix = 32768;
      armed = 0;
      mix_q.delete();
      err_count = 0;
      open_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_LEARNING_STEP) rate_q <= cfg_mon.data[LS_W-1:0];
        else if (cfg_mon.index == REG_DECAY_FACTOR) decay_q <= cfg_mon.data[DF_W-1:0];
      end
      // result first: an item taken this edge cannot be answered yet
      if (out_mon.valid && out_mon.ready) begin
        if (mix_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected word: mixed_probability=%0d", out_mon.mixed_probability);
        end else begin
          want = mix_q.pop_front();
          if (want !== out_mon.mixed_probability) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch mixed_probability: expected %0d got %0d",
                       want, out_mon.mixed_probability);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.func == FN_PREDICT) begin
          pr[0] = in_mon.prob_bit_model;
          pr[1] = in_mon.prob_byte_model;
          pr[2] = in_mon.prob_word_model;
          pr[3] = in_mon.prob_semantic_model;
          mix_predict(pr);
        end else begin
          mix_learn(in_mon.coded_bit);
        end
      end
      open_count = mix_q.size();
    end
  end

endmodule

// ----- tb/tb_online_logistic_probability_mixer.sv -----
// tb_online_logistic_probability_mixer: drives predict/update words and register
// writes into the mixer; checking is in olpm_mix_checker. Depends on olpm_pkg, olpm_tb_pkg, olpm_ifs.
module tb_online_logistic_probability_mixer;
  timeunit 1ns;
  timeprecision 1ps;
  import olpm_pkg::*;
  import olpm_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  int   err_count;
  int   open_count;
  int   quiet_cycles;
  bit   idle_on;

  olpm_in_if  in_ch ();
  olpm_out_if out_ch ();
  olpm_cfg_if cfg_ch ();

  online_logistic_probability_mixer u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  olpm_mix_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .err_count(err_count), .open_count(open_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_online_logistic_probability_mixer: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    int n;
    out_ch.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      n = idle_on ? $urandom_range(0, 8) : 0;
      if (n > 0) begin
        out_ch.ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_word(input logic fn, input logic [PROB_W-1:0] a, b, c, d,
                           input logic cb);
    int n;
    n = idle_on ? $urandom_range(0, 8) : 0;
    if (n > 0) begin
      in_ch.valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.func <= fn;
    in_ch.prob_bit_model <= a;
    in_ch.prob_byte_model <= b;
    in_ch.prob_word_model <= c;
    in_ch.prob_semantic_model <= d;
    in_ch.coded_bit <= cb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    // an update may still be running its weight steps
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
  endtask

  function automatic logic [PROB_W-1:0] pick_prob();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 16'hFFFF;
      2: return PROB_W'($urandom_range(1, 40));
      3: return PROB_W'($urandom_range(65495, 65535));
      default: return PROB_W'($urandom);
    endcase
  endfunction

  task automatic predict_rand();
    send_word(FN_PREDICT, pick_prob(), pick_prob(), pick_prob(), pick_prob(), 1'($urandom));
  endtask

  task automatic update_rand();
    send_word(FN_UPDATE, PROB_W'($urandom), PROB_W'($urandom), PROB_W'($urandom),
              PROB_W'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [LS_W-1:0] rates [5];
    logic [DF_W-1:0] decays [5];
    in_ch.valid = 0;
    in_ch.func = FN_PREDICT;
    in_ch.prob_bit_model = 0;
    in_ch.prob_byte_model = 0;
    in_ch.prob_word_model = 0;
    in_ch.prob_semantic_model = 0;
    in_ch.coded_bit = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = 0;
    cfg_ch.data = 0;
    idle_on = 1;
    rst_n = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: defaults, extremes, update with nothing pending, double predict
    send_word(FN_UPDATE, 0, 0, 0, 0, 1);
    send_word(FN_PREDICT, 0, 0, 0, 0, 0);
    send_word(FN_UPDATE, 0, 0, 0, 0, 1);
    send_word(FN_PREDICT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
    send_word(FN_UPDATE, 0, 0, 0, 0, 0);
    send_word(FN_PREDICT, 16'h0001, 16'hFFFF, 16'h0000, 16'hFFFE, 0);
    send_word(FN_PREDICT, 16'h8000, 16'h0001, 16'hFFFF, 16'h8000, 0);
    send_word(FN_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
    send_word(FN_UPDATE, 0, 0, 0, 0, 0);
    settle();
    write_reg(REG_LEARNING_STEP, 32'hFFFF_FFFF);
    write_reg(REG_DECAY_FACTOR, 32'hFFFF_FFFF);
    write_reg(8'd5, 32'd7);
    send_word(FN_PREDICT, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 0);
    send_word(FN_UPDATE, 0, 0, 0, 0, 0);
    send_word(FN_PREDICT, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_word(FN_UPDATE, 0, 0, 0, 0, 1);
    send_word(FN_PREDICT, 16'h4000, 16'hC000, 16'h2000, 16'hE000, 0);
    send_word(FN_UPDATE, 0, 0, 0, 0, 1);
    settle();

    rates = '{22'd0, 22'h3FFFFF, LS_RESET, 22'd2000000, 22'd0};
    decays = '{16'd0, 16'hFFFF, DF_RESET, 16'd0, 16'hFFFF};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_LEARNING_STEP, ph == 3 ? 32'($urandom) : 32'(rates[ph]));
      write_reg(REG_DECAY_FACTOR, 32'(decays[ph]));
      idle_on = (ph != 2);
      for (int k = 0; k < 120; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          predict_rand();
          update_rand();
        end else if ($urandom_range(0, 1)) begin
          predict_rand();
        end else begin
          update_rand();
        end
      end
      settle();
    end

    idle_on = 1;
    for (int t = 0; t < 30; t++) begin
      wait (open_count == 0);
      while (open_count != 0) @(posedge clk);
      settle();
    end

    while (open_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0)
      $display("tb_online_logistic_probability_mixer: done, clean");
    else
      $display("tb_online_logistic_probability_mixer: done, errors");
    $finish;
  end

endmodule
